/* hdl/idle_task_queue_with_cancel_defines.svh */
// assertion macros of the idle task queue port checker
// depends on nothing; included by the checker file
`ifndef IDLE_TASK_QUEUE_WITH_CANCEL_DEFINES_SVH
`define IDLE_TASK_QUEUE_WITH_CANCEL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ITQC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("itqc same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ITQC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("itqc next-cycle check failed");

`endif

/* hdl/itqc_pkg.sv */
// shared types and constants of the idle task queue
// no dependencies; imported by every module of the block
`default_nettype none

package itqc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_W        = 32;
    localparam int TAG_W           = 32;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_IDLE    = 2'd2
    } cmd_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_ISSUED   = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_CANCEL   = 3'd2,
        KIND_PERIOD   = 3'd3,
        KIND_DISPATCH = 3'd4,
        KIND_NOWORK   = 3'd5
    } kind_t;

    // one queue entry as stored in memory
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
    } entry_t;

    // one result as handed from the sequencer to the output register
    typedef struct packed {
        kind_t               kind;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
        logic                found;
        logic                progress;
    } result_t;

endpackage

`default_nettype wire

/* hdl/idle_task_queue_with_cancel.sv */
// Idle task queue with cancel by handle. Entries (handle and callback tag) live in a
// single synchronous memory of QUEUE_DEPTH entries; a sequencer reads, compares and
// writes back one entry per cycle, and a result register on the output lets the next
// transaction be accepted while a result waits. One transaction is worked on at a
// time; the next one can be accepted in the cycle after its result is loaded, and a
// result that finds the output register still full waits until that register drains.
// A request, a period start, a full rejection, a no-work tick or a cancel of handle
// zero go from acceptance straight to the done state, where the result waits for the
// output register. A dispatch reads the head entry and then moves every later entry
// down one place. A cancel scans the pending part and compacts behind a match, then
// scans the runnable part and compacts behind a match there too. The single memory
// read port delivers one entry per cycle. No clearing pass after reset.
`default_nettype none

module idle_task_queue_with_cancel #(
    parameter int QUEUE_DEPTH = itqc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_cmd,
    input  wire logic [itqc_pkg::TAG_W-1:0]    s_callback_tag,
    input  wire logic [itqc_pkg::HANDLE_W-1:0] s_cancel_handle,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_result_kind,
    output logic [itqc_pkg::HANDLE_W-1:0]      m_handle,
    output logic [itqc_pkg::TAG_W-1:0]         m_dispatched_tag,
    output logic                               m_cancel_found,
    output logic                               m_made_progress
);
    import itqc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    itqc_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_callback_tag  (s_callback_tag),
        .s_cancel_handle (s_cancel_handle),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    itqc_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = m_res_reg.kind;
    assign m_handle         = m_res_reg.handle;
    assign m_dispatched_tag = m_res_reg.tag;
    assign m_cancel_found   = m_res_reg.found;
    assign m_made_progress  = m_res_reg.progress;

endmodule

`default_nettype wire

/* hdl/itqc_mem.sv */
// entry memory: one write port, one read port, registered read data
// depends on itqc_pkg for the entry type
`default_nettype none

module itqc_mem #(
    parameter int DEPTH = itqc_pkg::QUEUE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire itqc_pkg::entry_t wdata,
    input  wire logic [AW-1:0]   raddr,
    output itqc_pkg::entry_t     rdata
);
    import itqc_pkg::*;

    entry_t mem_array [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/itqc_ctrl.sv */
// queue sequencer: counters, handle counter, scan and compaction over the entry memory
// depends on itqc_pkg; drives the ports of itqc_mem
`default_nettype none

module itqc_ctrl #(
    parameter int QUEUE_DEPTH = itqc_pkg::QUEUE_DEPTH_DEF,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_cmd,
    input  wire logic [itqc_pkg::TAG_W-1:0]    s_callback_tag,
    input  wire logic [itqc_pkg::HANDLE_W-1:0] s_cancel_handle,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output itqc_pkg::result_t                  res,
    output logic                               mem_we,
    output logic [AW-1:0]                      mem_waddr,
    output itqc_pkg::entry_t                   mem_wdata,
    output logic [AW-1:0]                      mem_raddr,
    input  wire itqc_pkg::entry_t              mem_rdata
);
    import itqc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP_RD,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_DISP,
        OP_PEND,
        OP_RUN
    } op_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [CW-1:0]       ec_reg, ec_next;
    logic [CW-1:0]       rc_reg, rc_next;
    logic [HANDLE_W-1:0] last_handle_reg, last_handle_next;
    logic [HANDLE_W-1:0] want_reg, want_next;
    logic [CW-1:0]       scan_pos_reg, scan_pos_next;
    logic [CW-1:0]       scan_hi_reg, scan_hi_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [CW-1:0]       chk_pos_reg, chk_pos_next;
    logic [CW-1:0]       del_pos_reg, del_pos_next;
    logic                found_reg, found_next;
    result_t             res_reg, res_next;

    logic [HANDLE_W-1:0] new_handle;
    logic [CW-1:0]       wr_pos;
    logic                hit;

    // next handle, skipping zero on wrap
    always_comb begin
        new_handle = last_handle_reg + HANDLE_W'(1);
        if (new_handle == '0) begin
            new_handle = HANDLE_W'(1);
        end
    end

    assign wr_pos = chk_pos_reg - CW'(1);
    assign hit    = chk_valid_reg && (mem_rdata.handle == want_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;
    assign mem_raddr = (state_reg == ST_IDLE) ? '0 : scan_pos_reg[AW-1:0];

    // sequencer next state
    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        ec_next          = ec_reg;
        rc_next          = rc_reg;
        last_handle_next = last_handle_reg;
        want_next        = want_reg;
        scan_pos_next    = scan_pos_reg;
        scan_hi_next     = scan_hi_reg;
        chk_valid_next   = chk_valid_reg;
        chk_pos_next     = chk_pos_reg;
        del_pos_next     = del_pos_reg;
        found_next       = found_reg;
        res_next         = res_reg;
        mem_we           = 1'b0;
        mem_waddr        = ec_reg[AW-1:0];
        mem_wdata.handle = new_handle;
        mem_wdata.tag    = s_callback_tag;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    want_next         = s_cancel_handle;
                    found_next        = 1'b0;
                    res_next.kind     = KIND_NOWORK;
                    res_next.handle   = '0;
                    res_next.tag      = '0;
                    res_next.found    = 1'b0;
                    res_next.progress = 1'b0;
                    state_next        = ST_DONE;
                    case (s_cmd)
                        CMD_REQUEST: begin
                            if (ec_reg == CW'(QUEUE_DEPTH)) begin
                                res_next.kind = KIND_FULL;
                            end else begin
                                mem_we           = 1'b1;
                                last_handle_next = new_handle;
                                ec_next          = ec_reg + CW'(1);
                                res_next.kind    = KIND_ISSUED;
                                res_next.handle  = new_handle;
                            end
                        end
                        CMD_CANCEL: begin
                            res_next.kind = KIND_CANCEL;
                            if (s_cancel_handle != '0) begin
                                // search the pending part first
                                op_next        = OP_PEND;
                                scan_pos_next  = rc_reg;
                                scan_hi_next   = ec_reg;
                                chk_valid_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        CMD_IDLE: begin
                            if (rc_reg != '0 && ec_reg != '0) begin
                                // head entry is read at address zero this cycle
                                op_next    = OP_DISP;
                                state_next = ST_DISP_RD;
                            end else if (ec_reg != '0) begin
                                rc_next           = ec_reg;
                                res_next.kind     = KIND_PERIOD;
                                res_next.progress = 1'b1;
                            end
                        end
                        default: begin
                            res_next.kind = KIND_NOWORK;
                        end
                    endcase
                end
            end

            ST_DISP_RD: begin
                // capture head entry, then close the gap at position zero
                res_next.kind     = KIND_DISPATCH;
                res_next.handle   = mem_rdata.handle;
                res_next.tag      = mem_rdata.tag;
                res_next.progress = 1'b1;
                del_pos_next      = '0;
                scan_pos_next     = CW'(1);
                chk_valid_next    = 1'b0;
                state_next        = ST_SHIFT;
            end

            ST_SCAN: begin
                if (hit) begin
                    del_pos_next   = chk_pos_reg;
                    scan_pos_next  = chk_pos_reg + CW'(1);
                    chk_valid_next = 1'b0;
                    state_next     = ST_SHIFT;
                end else if (!chk_valid_reg && scan_pos_reg >= scan_hi_reg) begin
                    // range exhausted without a match
                    if (op_reg == OP_PEND) begin
                        op_next       = OP_RUN;
                        scan_pos_next = '0;
                        scan_hi_next  = rc_reg;
                    end else begin
                        res_next.found = found_reg;
                        state_next     = ST_DONE;
                    end
                end else begin
                    chk_valid_next = (scan_pos_reg < scan_hi_reg);
                    chk_pos_next   = scan_pos_reg;
                    if (scan_pos_reg < scan_hi_reg) begin
                        scan_pos_next = scan_pos_reg + CW'(1);
                    end
                end
            end

            ST_SHIFT: begin
                // move the entry read last cycle down by one place
                if (chk_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_pos[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (!chk_valid_reg && scan_pos_reg >= ec_reg) begin
                    ec_next = ec_reg - CW'(1);
                    if (del_pos_reg < rc_reg) begin
                        rc_next = rc_reg - CW'(1);
                    end
                    case (op_reg)
                        OP_PEND: begin
                            found_next     = 1'b1;
                            op_next        = OP_RUN;
                            scan_pos_next  = '0;
                            scan_hi_next   = rc_reg;
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        OP_RUN: begin
                            res_next.found = 1'b1;
                            state_next     = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end else begin
                    chk_valid_next = (scan_pos_reg < ec_reg);
                    chk_pos_next   = scan_pos_reg;
                    if (scan_pos_reg < ec_reg) begin
                        scan_pos_next = scan_pos_reg + CW'(1);
                    end
                end
            end

            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_DISP;
            ec_reg          <= '0;
            rc_reg          <= '0;
            last_handle_reg <= '0;
            chk_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            ec_reg          <= ec_next;
            rc_reg          <= rc_next;
            last_handle_reg <= last_handle_next;
            chk_valid_reg   <= chk_valid_next;
            found_reg       <= found_next;
        end
        want_reg     <= want_next;
        scan_pos_reg <= scan_pos_next;
        scan_hi_reg  <= scan_hi_next;
        chk_pos_reg  <= chk_pos_next;
        del_pos_reg  <= del_pos_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

/* hdl/itqc_chk.sv */
// port-level checker for the idle task queue, bound to the top level
// depends on itqc_pkg and the assertion macros header
`default_nettype none
`include "idle_task_queue_with_cancel_defines.svh"

module itqc_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [2:0]                    m_result_kind,
    input wire logic [itqc_pkg::HANDLE_W-1:0] m_handle,
    input wire logic                          m_cancel_found,
    input wire logic                          m_made_progress
);
    import itqc_pkg::*;

    logic [1:0] open_reg, open_next;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // transactions accepted but not yet delivered
    always_comb begin
        open_next = open_reg;
        if (s_fire && !m_fire) begin
            open_next = open_reg + 2'd1;
        end else if (m_fire && !s_fire) begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 2'd0;
        end else begin
            open_reg <= open_next;
        end
    end

    // a stalled result holds
    `ITQC_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_handle) && $stable(m_result_kind))

    // no result without an accepted transaction, never more than two in flight
    `ITQC_ASSERT_IMP(a_result_owed, aclk, aresetn, m_valid, open_reg != 2'd0 && open_reg != 2'd3)

    // an issued handle is never zero
    `ITQC_ASSERT_IMP(a_handle_nonzero, aclk, aresetn, m_valid && m_result_kind == KIND_ISSUED, m_handle != '0)

    // progress and found flags agree with the kind
    `ITQC_ASSERT_IMP(a_flags_kind, aclk, aresetn, m_valid, (m_made_progress == (m_result_kind == KIND_DISPATCH || m_result_kind == KIND_PERIOD)) && (!m_cancel_found || m_result_kind == KIND_CANCEL))

endmodule

bind idle_task_queue_with_cancel itqc_chk u_itqc_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_kind   (m_result_kind),
    .m_handle        (m_handle),
    .m_cancel_found  (m_cancel_found),
    .m_made_progress (m_made_progress)
);

`default_nettype wire

/* tb/task_queue_checker.sv */
// watches both channels of the idle task queue, predicts each result and compares
// depends on itqc_pkg; instantiated beside the block by the testbench top
`default_nettype none

module task_queue_checker #(
    parameter int QUEUE_DEPTH = itqc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_callback_tag,
    input  logic [31:0] s_cancel_handle,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_result_kind,
    input  logic [31:0] m_handle,
    input  logic [31:0] m_dispatched_tag,
    input  logic        m_cancel_found,
    input  logic        m_made_progress,
    output int          fail_count,
    output int          outcomes_waiting
);
    import itqc_pkg::*;

    localparam int MAX_REPORTS = 10;

    // shadow copy of the task queue
    entry_t      slots [QUEUE_DEPTH];
    int unsigned n_entries;
    int unsigned n_runnable;
    logic [31:0] last_issued;

    result_t outcomes [$];
    int      mismatches;
    result_t want_res;

    initial begin
        fail_count       = 0;
        outcomes_waiting = 0;
        mismatches       = 0;
    end

    // remove one entry and close the gap behind it
    function automatic void remove_slot(int unsigned pos);
        for (int unsigned i = pos + 1; i < n_entries; i++) begin
            slots[i-1] = slots[i];
        end
        n_entries--;
        if (pos < n_runnable) begin
            n_runnable--;
        end
    endfunction

    // first position in [lo, hi) holding handle h, or hi when there is none
    function automatic int unsigned locate(int unsigned lo, int unsigned hi, logic [31:0] h);
        for (int unsigned i = lo; i < hi; i++) begin
            if (slots[i].handle == h) begin
                return i;
            end
        end
        return hi;
    endfunction

    // apply one command to the shadow queue and return the result it produces
    function automatic result_t run_queue_command(logic [1:0] cmd, logic [31:0] tag,
                                                  logic [31:0] target);
        result_t     r;
        int unsigned p;
        r      = '0;
        r.kind = KIND_NOWORK;
        case (cmd)
            CMD_REQUEST: begin
                if (n_entries >= QUEUE_DEPTH) begin
                    r.kind = KIND_FULL;
                end else begin
                    // wrapping counter that never hands out zero
                    r.handle = last_issued + 32'd1;
                    if (r.handle == '0) begin
                        r.handle = 32'd1;
                    end
                    last_issued             = r.handle;
                    slots[n_entries].handle = r.handle;
                    slots[n_entries].tag    = tag;
                    n_entries++;
                    r.kind = KIND_ISSUED;
                end
            end
            CMD_CANCEL: begin
                r.kind = KIND_CANCEL;
                if (target != '0) begin
                    // pending part first, then the runnable run
                    p = locate(n_runnable, n_entries, target);
                    if (p < n_entries) begin
                        remove_slot(p);
                        r.found = 1'b1;
                    end
                    p = locate(0, n_runnable, target);
                    if (p < n_runnable) begin
                        remove_slot(p);
                        r.found = 1'b1;
                    end
                end
            end
            CMD_IDLE: begin
                if (n_runnable > 0 && n_entries > 0) begin
                    r.handle = slots[0].handle;
                    r.tag    = slots[0].tag;
                    remove_slot(0);
                    r.kind     = KIND_DISPATCH;
                    r.progress = 1'b1;
                end else if (n_entries > 0) begin
                    n_runnable = n_entries;
                    r.kind     = KIND_PERIOD;
                    r.progress = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // compare result transactions, then record the outcome of each accepted command
    always @(posedge aclk) begin
        if (!aresetn) begin
            n_entries   = 0;
            n_runnable  = 0;
            last_issued = '0;
            outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result kind %0d handle %h arrived with nothing awaited",
                                 $realtime, m_result_kind, m_handle);
                    end
                end else begin
                    want_res = outcomes.pop_front();
                    if (m_result_kind !== want_res.kind || m_handle !== want_res.handle ||
                        m_dispatched_tag !== want_res.tag ||
                        m_cancel_found !== want_res.found ||
                        m_made_progress !== want_res.progress) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: expected kind %0d handle %h tag %h found %b prog %b",
                                     $realtime, want_res.kind, want_res.handle, want_res.tag,
                                     want_res.found, want_res.progress);
                            $display("%0t: actual   kind %0d handle %h tag %h found %b prog %b",
                                     $realtime, m_result_kind, m_handle, m_dispatched_tag,
                                     m_cancel_found, m_made_progress);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                outcomes.push_back(run_queue_command(s_cmd, s_callback_tag, s_cancel_handle));
            end
        end
        outcomes_waiting <= outcomes.size();
        fail_count       <= mismatches;
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// top of the idle task queue testbench: clock, reset, command stimulus and verdict
// depends on itqc_pkg, idle_task_queue_with_cancel and task_queue_checker
`default_nettype none

module testbench;
    import itqc_pkg::*;

    localparam int         DEPTH        = QUEUE_DEPTH_DEF;
    localparam int         RANDOM_ITEMS = 900;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         RESET_CYCLES = 12;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic [1:0]  s_cmd           = CMD_IDLE;
    logic [31:0] s_callback_tag  = '0;
    logic [31:0] s_cancel_handle = '0;
    logic        m_ready         = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_result_kind;
    logic [31:0] m_handle;
    logic [31:0] m_dispatched_tag;
    logic        m_cancel_found;
    logic        m_made_progress;

    int          fail_count;
    int          outcomes_waiting;
    int unsigned cycle_count = 0;
    bit          steady_flow = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned stall_len;
    logic [31:0] seen_handles [$];

    initial begin
        forever #2 aclk = ~aclk;
    end

    idle_task_queue_with_cancel #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_callback_tag   (s_callback_tag),
        .s_cancel_handle  (s_cancel_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_handle         (m_handle),
        .m_dispatched_tag (m_dispatched_tag),
        .m_cancel_found   (m_cancel_found),
        .m_made_progress  (m_made_progress)
    );

    task_queue_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_callback_tag   (s_callback_tag),
        .s_cancel_handle  (s_cancel_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_handle         (m_handle),
        .m_dispatched_tag (m_dispatched_tag),
        .m_cancel_found   (m_cancel_found),
        .m_made_progress  (m_made_progress),
        .fail_count       (fail_count),
        .outcomes_waiting (outcomes_waiting)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            stall_len = steady_flow ? 0 : pick_gap();
            m_ready    <= (stall_len == 0);
            stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    // remember recently issued handles so cancels can aim at live entries
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_result_kind == KIND_ISSUED) begin
            seen_handles.push_back(m_handle);
            if (seen_handles.size() > 24) begin
                void'(seen_handles.pop_front());
            end
        end
    end

    function automatic logic [31:0] pick_cancel_handle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return '0;
        end
        if (r < 12) begin
            return 32'hFFFF_FFFF;
        end
        if (r < 22 || seen_handles.size() == 0) begin
            return $urandom;
        end
        if (r < 28) begin
            return seen_handles[$] + 32'd1;
        end
        return seen_handles[$urandom_range(0, seen_handles.size() - 1)];
    endfunction

    // drive one input transaction and hold it until accepted
    task automatic push_txn(input logic [1:0] cmd, input logic [31:0] tag,
                            input logic [31:0] target);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_callback_tag  <= tag;
        s_cancel_handle <= target;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // stop sending until every awaited result has come back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outcomes_waiting != 0);
    endtask

    initial begin
        int unsigned sent;
        int unsigned n;
        int unsigned r;
        int unsigned phase;
        int unsigned req_cut;
        int unsigned cancel_cut;
        int unsigned idle_cut;
        logic [1:0]  cmd;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty queue, unused command, cancel of nothing
        push_txn(CMD_IDLE, 32'h0, 32'h0);
        push_txn(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_txn(CMD_CANCEL, 32'h0, 32'h0);
        // two requests, promote them, one pending behind
        push_txn(CMD_REQUEST, 32'h0000_0000, 32'h0);
        push_txn(CMD_REQUEST, 32'hFFFF_FFFF, 32'h0);
        push_txn(CMD_IDLE, 32'h0, 32'h0);
        push_txn(CMD_REQUEST, 32'hA5A5_5A5A, 32'h0);
        // cancel in the runnable run, in the pending part, and an unknown handle
        push_txn(CMD_CANCEL, 32'h0, 32'd1);
        push_txn(CMD_CANCEL, 32'h0, 32'd3);
        push_txn(CMD_CANCEL, 32'h0, 32'hFFFF_FFFF);
        push_txn(CMD_IDLE, 32'h0, 32'h0);
        push_txn(CMD_IDLE, 32'h0, 32'h0);
        // fill to the brim, one more is turned away
        for (int i = 0; i <= DEPTH; i++) begin
            push_txn(CMD_REQUEST, $urandom, $urandom);
        end
        settle();

        // random traffic in phases that fill, drain or mix
        sent = 0;
        n    = 0;
        while (sent < RANDOM_ITEMS) begin
            if (n % 40 == 0) begin
                phase       = $urandom_range(0, 2);
                steady_flow = ($urandom_range(0, 3) == 0);
                case (phase)
                    0: begin req_cut = 70; cancel_cut = 85; idle_cut = 97; end
                    1: begin req_cut = 15; cancel_cut = 35; idle_cut = 97; end
                    default: begin req_cut = 40; cancel_cut = 65; idle_cut = 97; end
                endcase
            end
            if (n == RANDOM_ITEMS / 2) begin
                settle();
            end
            r = $urandom_range(0, 99);
            if (r < req_cut) begin
                cmd = CMD_REQUEST;
            end else if (r < cancel_cut) begin
                cmd = CMD_CANCEL;
            end else if (r < idle_cut) begin
                cmd = CMD_IDLE;
            end else begin
                cmd = CMD_UNUSED;
            end
            push_txn(cmd, $urandom,
                     (cmd == CMD_CANCEL) ? pick_cancel_handle() : $urandom);
            if (cmd != CMD_UNUSED) begin
                sent++;
            end
            n++;
        end

        // let the last results drain
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outcomes_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
